// ----- design/dofc_pkg.sv -----
// Shared constants for the depth-of-field calculator.
// No dependencies; used by dofc_div and depth_of_field_calc.
package dofc_pkg;

	localparam int DW = 32;            // datapath width
	localparam int DIV_STAGES = DW;    // one quotient bit per divider stage

	localparam logic [7:0]  COC_RESET   = 8'd19;
	localparam logic [9:0]  MM_PER_M    = 10'd1000;
	localparam logic [3:0]  MM_PER_CM   = 4'd10;
	localparam logic [DW-1:0] INFINITY_MM = 32'd1000000;

	localparam logic [1:0] STAT_FULL     = 2'd0;
	localparam logic [1:0] STAT_NO_FOCUS = 2'd1;
	localparam logic [1:0] STAT_NO_LENS  = 2'd2;

endpackage

// ----- design/dofc_div.sv -----
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
// Depends on dofc_pkg. A zero divisor gives an all-ones quotient.
module dofc_div
	import dofc_pkg::*;
(
	input  logic          clk,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [DW-1:0] quo
);

	logic [DW-1:0] rem_s [DIV_STAGES];
	logic [DW-1:0] n_s   [DIV_STAGES];
	logic [DW-1:0] d_s   [DIV_STAGES];
	logic [DW-1:0] q_s   [DIV_STAGES];

	genvar k;
	generate
		for (k = 0; k < DIV_STAGES; k++) begin : g_stage
			logic [DW-1:0] rem_in, n_in, d_in, q_in;
			logic [DW:0]   trial;
			logic          ge;

			if (k == 0) begin : g_first
				assign rem_in = '0;
				assign n_in   = num;
				assign d_in   = den;
				assign q_in   = '0;
			end else begin : g_next
				assign rem_in = rem_s[k-1];
				assign n_in   = n_s[k-1];
				assign d_in   = d_s[k-1];
				assign q_in   = q_s[k-1];
			end

			assign trial = {rem_in, n_in[DW-1]};
			assign ge    = (trial >= {1'b0, d_in});

			always_ff @(posedge clk) begin
				rem_s[k] <= ge ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
				n_s[k]   <= {n_in[DW-2:0], 1'b0};
				d_s[k]   <= d_in;
				q_s[k]   <= {q_in[DW-2:0], ge};
			end
		end
	endgenerate

	assign quo = q_s[DIV_STAGES-1];

endmodule

// ----- design/depth_of_field_calc.sv -----
// Top level of the depth-of-field calculator: hyperfocal, near and far limits.
// Depends on dofc_pkg and dofc_div.

// A lens request is taken on every cycle that start is high; busy is always
// low. Its result appears for a single cycle with done high, in request
// order, and must be captured then since the block cannot be held.
// A request passes through two 32-stage bit-per-cycle dividers in series (the
// hyperfocal division, then the near and far divisions side by side) plus
// five multiply, compare and output stages. coc_we writes the circle of
// confusion and should only be used while no request is in flight.
module depth_of_field_calc
	import dofc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] focus_cm,
	input  logic [15:0] focal_mm,
	input  logic [15:0] fnum_tenths,
	input  logic        coc_we,
	input  logic [7:0]  coc_wdata,
	output logic        done,
	output logic [31:0] hyperfocal_mm,
	output logic [31:0] near_mm,
	output logic [31:0] far_mm,
	output logic [1:0]  status
);

	logic [7:0] coc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coc_q <= COC_RESET;
		end else if (coc_we) begin
			coc_q <= coc_wdata;
		end
	end

	assign busy = 1'b0;

	// Stage 1: squares and divisor product.
	logic          v_s1, miss_s1;
	logic [DW-1:0] ffsq_s1;
	logic [23:0]   dv_s1;
	logic [15:0]   focus_s1;

	// Stage 2: numerator scale.
	logic          v_s2, miss_s2;
	logic [DW-1:0] num_s2, den_s2;
	logic [15:0]   focus_s2;

	// Side data alongside the hyperfocal divider.
	logic          va_d    [DIV_STAGES];
	logic          missa_d [DIV_STAGES];
	logic [15:0]   focusa_d[DIV_STAGES];
	logic [DW-1:0] quo_a;

	// Stage 3: hyperfocal distance.
	logic          v_s3, miss_s3;
	logic [DW-1:0] h_s3;
	logic [15:0]   focus_s3;

	// Stage 4: near and far operands.
	logic          v_s4, inf_s4, sumz_s4;
	logic [1:0]    stat_s4;
	logic [DW-1:0] h_s4, prod_s4, sum_s4, diff_s4;

	logic          vb_d    [DIV_STAGES];
	logic          infb_d  [DIV_STAGES];
	logic          sumzb_d [DIV_STAGES];
	logic [1:0]    statb_d [DIV_STAGES];
	logic [DW-1:0] hb_d    [DIV_STAGES];
	logic [DW-1:0] quo_near, quo_far;

	// Stage 5: output register.
	logic          v_s5;
	logic [1:0]    stat_s5;
	logic [DW-1:0] h_s5, near_s5, far_s5;

	logic [DW-1:0] fd_w;
	assign fd_w = {16'd0, focus_s3} * MM_PER_CM;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 0; i < DIV_STAGES; i++) begin
				va_d[i] <= 1'b0;
				vb_d[i] <= 1'b0;
			end
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			va_d[0] <= v_s2;
			vb_d[0] <= v_s4;
			for (int i = 1; i < DIV_STAGES; i++) begin
				va_d[i] <= va_d[i-1];
				vb_d[i] <= vb_d[i-1];
			end
			v_s3 <= va_d[DIV_STAGES-1];
			v_s4 <= v_s3;
			v_s5 <= vb_d[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		ffsq_s1  <= focal_mm * focal_mm;
		dv_s1    <= fnum_tenths * coc_q;
		miss_s1  <= (focal_mm == 16'd0) || (fnum_tenths == 16'd0) || (coc_q == 8'd0);
		focus_s1 <= focus_cm;

		num_s2   <= DW'(ffsq_s1 * MM_PER_M);
		den_s2   <= {8'd0, dv_s1};
		miss_s2  <= miss_s1;
		focus_s2 <= focus_s1;

		missa_d[0]  <= miss_s2;
		focusa_d[0] <= focus_s2;
		for (int i = 1; i < DIV_STAGES; i++) begin
			missa_d[i]  <= missa_d[i-1];
			focusa_d[i] <= focusa_d[i-1];
		end

		h_s3     <= DW'(quo_a * MM_PER_CM);
		miss_s3  <= missa_d[DIV_STAGES-1];
		focus_s3 <= focusa_d[DIV_STAGES-1];

		h_s4    <= h_s3;
		prod_s4 <= DW'(h_s3 * focus_s3);
		sum_s4  <= DW'(h_s3 + fd_w[DW-1:0]);
		diff_s4 <= DW'(h_s3 - fd_w[DW-1:0]);
		sumz_s4 <= (DW'(h_s3 + fd_w[DW-1:0]) == '0);
		inf_s4  <= (fd_w[DW-1:0] >= h_s3);
		if (miss_s3) begin
			stat_s4 <= STAT_NO_LENS;
		end else if (focus_s3 == 16'd0) begin
			stat_s4 <= STAT_NO_FOCUS;
		end else begin
			stat_s4 <= STAT_FULL;
		end

		infb_d[0]  <= inf_s4;
		sumzb_d[0] <= sumz_s4;
		statb_d[0] <= stat_s4;
		hb_d[0]    <= h_s4;
		for (int i = 1; i < DIV_STAGES; i++) begin
			infb_d[i]  <= infb_d[i-1];
			sumzb_d[i] <= sumzb_d[i-1];
			statb_d[i] <= statb_d[i-1];
			hb_d[i]    <= hb_d[i-1];
		end

		stat_s5 <= statb_d[DIV_STAGES-1];
		case (statb_d[DIV_STAGES-1])
			STAT_FULL: begin
				h_s5    <= hb_d[DIV_STAGES-1];
				near_s5 <= sumzb_d[DIV_STAGES-1] ? '0 : DW'(quo_near * MM_PER_CM);
				far_s5  <= infb_d[DIV_STAGES-1] ? INFINITY_MM : DW'(quo_far * MM_PER_CM);
			end
			STAT_NO_FOCUS: begin
				h_s5    <= hb_d[DIV_STAGES-1];
				near_s5 <= '0;
				far_s5  <= '0;
			end
			default: begin
				h_s5    <= '0;
				near_s5 <= '0;
				far_s5  <= '0;
			end
		endcase
	end

	dofc_div u_div_h (
		.clk (clk),
		.num (num_s2),
		.den (den_s2),
		.quo (quo_a)
	);

	dofc_div u_div_near (
		.clk (clk),
		.num (prod_s4),
		.den (sum_s4),
		.quo (quo_near)
	);

	dofc_div u_div_far (
		.clk (clk),
		.num (prod_s4),
		.den (diff_s4),
		.quo (quo_far)
	);

	assign done          = v_s5;
	assign hyperfocal_mm = h_s5;
	assign near_mm       = near_s5;
	assign far_mm        = far_s5;
	assign status        = stat_s5;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##69 done)
		else $error("result strobe missing after fixed latency");

	a_no_lens_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_NO_LENS) |->
		(hyperfocal_mm == '0 && near_mm == '0 && far_mm == '0))
		else $error("missing lens data must give zero distances");

	a_no_focus_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_NO_FOCUS) |-> (near_mm == '0 && far_mm == '0))
		else $error("missing focus must give zero limits");
`endif

endmodule
